>>> hdl/priority_inheritance_tracker_defines.svh
// Assertion macros shared by the tracker modules.
// They expect signals named clk and rst_n in the enclosing scope.
`ifndef PRIORITY_INHERITANCE_TRACKER_DEFINES_SVH
`define PRIORITY_INHERITANCE_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PIT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pit assertion failed");

// Next-cycle implication, checked outside reset.
`define PIT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pit assertion failed");

`endif

>>> hdl/pit_pkg.sv
`timescale 1ns / 1ps
package pit_pkg;

  localparam int PRIO_W   = 32;
  localparam int LOCK_W   = 16;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_RAISED     = 3'd0,
    ST_NULL       = 3'd1,
    ST_NOT_HIGHER = 3'd2,
    ST_FULL       = 3'd3,
    ST_RELEASED   = 3'd4,
    ST_NOT_FOUND  = 3'd5
  } status_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } pit_state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch request, reset scan
    logic rd_en;   // read slot at scan index
    logic fin;     // commit result
  } pit_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_idx;  // scan index at final slot
    logic out_busy;  // result register held
  } pit_sts_t;

endpackage

>>> hdl/pit_ctrl.sv
`timescale 1ns / 1ps
`include "priority_inheritance_tracker_defines.svh"
module pit_ctrl
  import pit_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  pit_sts_t sts,
  output pit_cmd_t cmd
);

  pit_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.last_idx) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      S_FIN: begin
        cmd.fin = !sts.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `PIT_ASSERT_NXT(a_start_scans, cmd.start, state_r == S_SCAN)
  `PIT_ASSERT_NXT(a_scan_drains, (state_r == S_SCAN) && sts.last_idx, state_r == S_DRAIN)
  `PIT_ASSERT_IMP(a_fin_single, cmd.fin, !cmd.rd_en && !cmd.start)

endmodule

>>> hdl/pit_dp.sv
`timescale 1ns / 1ps
`include "priority_inheritance_tracker_defines.svh"
module pit_dp
  import pit_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pit_cmd_t          cmd,
  output pit_sts_t          sts,
  input  logic              in_tuser,
  input  logic [47:0]       in_tdata,
  input  logic              cfg_wen,
  input  logic [PRIO_W-1:0] cfg_wdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,
  output logic [2:0]        out_tuser
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // slot table: lock id and saved priority per entry, used flags in flops
  logic [LOCK_W-1:0] lock_mem [SLOTS];
  logic [PRIO_W-1:0] prio_mem [SLOTS];
  logic [SLOTS-1:0]  slot_vld_r;

  // request
  req_t              req_type_r;
  logic [LOCK_W-1:0] req_lock_r;
  logic [PRIO_W-1:0] req_prio_r;

  // priorities
  logic [PRIO_W-1:0] init_prio_r;
  logic [PRIO_W-1:0] cur_prio_r, cur_prio_nxt;

  // scan
  logic [IDX_W-1:0]  idx_r;
  logic              q_vld_r;
  logic [IDX_W-1:0]  q_idx_r;
  logic              q_used_r;
  logic [LOCK_W-1:0] q_lock_r;
  logic [PRIO_W-1:0] q_prio_r;
  logic              q_match;

  // scan accumulators
  logic              found_r;
  logic [PRIO_W-1:0] best_r;
  logic              have_free_r;
  logic [IDX_W-1:0]  free_idx_r;

  // result
  status_t           res_status;
  logic              res_requeue;
  logic              res_dispatch;
  logic              slot_wr;
  logic              out_vld_r;
  logic [PRIO_W-1:0] out_prio_r;
  status_t           out_status_r;
  logic              out_requeue_r;
  logic              out_dispatch_r;

  assign sts.last_idx = (idx_r == IDX_W'(SLOTS - 1));
  assign sts.out_busy = out_vld_r && !out_tready;

  assign q_match = q_vld_r && q_used_r && (q_lock_r == req_lock_r) &&
                   (req_type_r == REQ_POP);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_type_r <= req_t'(in_tuser);
      req_lock_r <= in_tdata[LOCK_W-1:0];
      req_prio_r <= in_tdata[LOCK_W +: PRIO_W];
    end
  end

  // memory: one read port at scan index, one write port at free index
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      q_lock_r <= lock_mem[idx_r];
      q_prio_r <= prio_mem[idx_r];
      q_used_r <= slot_vld_r[idx_r];
      q_idx_r  <= idx_r;
    end
    if (slot_wr) begin
      lock_mem[free_idx_r] <= req_lock_r;
      prio_mem[free_idx_r] <= cur_prio_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      q_vld_r    <= 1'b0;
      idx_r      <= '0;
    end else begin
      q_vld_r <= cmd.rd_en;
      if (cmd.start) begin
        idx_r <= '0;
      end else if (cmd.rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
      if (q_match) begin
        slot_vld_r[q_idx_r] <= 1'b0;
      end
      if (slot_wr) begin
        slot_vld_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found_r     <= 1'b0;
      best_r      <= init_prio_r;
      have_free_r <= 1'b0;
      free_idx_r  <= '0;
    end else if (q_vld_r) begin
      if (q_match) begin
        found_r <= 1'b1;
      end else if (q_used_r && (q_prio_r > best_r)) begin
        best_r <= q_prio_r;
      end
      if (!have_free_r && !q_used_r) begin
        have_free_r <= 1'b1;
        free_idx_r  <= q_idx_r;
      end
    end
  end

  always_comb begin
    cur_prio_nxt = cur_prio_r;
    res_status   = ST_NULL;
    res_requeue  = 1'b0;
    res_dispatch = 1'b0;
    slot_wr      = 1'b0;
    if (req_lock_r == '0) begin
      res_status = ST_NULL;
    end else if (req_type_r == REQ_PUSH) begin
      if (req_prio_r <= cur_prio_r) begin
        res_status = ST_NOT_HIGHER;
      end else begin
        cur_prio_nxt = req_prio_r;
        res_requeue  = 1'b1;
        if (have_free_r) begin
          res_status = ST_RAISED;
          slot_wr    = cmd.fin;
        end else begin
          res_status = ST_FULL;
        end
      end
    end else if (!found_r) begin
      res_status = ST_NOT_FOUND;
    end else begin
      res_status = ST_RELEASED;
      if (best_r != '0) begin
        cur_prio_nxt = best_r;
        res_dispatch = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_prio_r <= '0;
      cur_prio_r  <= '0;
    end else if (cfg_wen) begin
      init_prio_r <= cfg_wdata;
      cur_prio_r  <= cfg_wdata;
    end else if (cmd.fin) begin
      cur_prio_r <= cur_prio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.fin) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_prio_r     <= cur_prio_nxt;
      out_status_r   <= res_status;
      out_requeue_r  <= res_requeue;
      out_dispatch_r <= res_dispatch;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_dispatch_r, out_requeue_r, out_prio_r};
  assign out_tuser  = out_status_r;

  `PIT_ASSERT_IMP(a_flags_excl, out_vld_r, !(out_requeue_r && out_dispatch_r))
  `PIT_ASSERT_NXT(a_not_found_keeps, cmd.fin && !cfg_wen && (res_status == ST_NOT_FOUND),
                  cur_prio_r == $past(cur_prio_r))
  `PIT_ASSERT_NXT(a_one_slot_taken, cmd.fin,
                  $countones(slot_vld_r) <= $countones($past(slot_vld_r)) + 1)

endmodule

>>> hdl/priority_inheritance_tracker.sv
`timescale 1ns / 1ps
// An accepted item passes the table scan (one slot per cycle), a drain step and the result commit;
// the next item is accepted only once the result has been committed to the output register.
// A finished result waits in the output register; the next item is taken meanwhile.
// Reset (rst_n, synchronous, active low) frees all slots and zeroes both priorities.
// No clearing pass: the table is usable in the first cycle after reset.
module priority_inheritance_tracker
  import pit_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // request items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] lock_id, [47:16] new_priority
  input  logic        in_tuser,   // [0] req_type (0 push, 1 pop)
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] effective_priority, [32] requeue,
                                  // [33] dispatch_now, [39:34] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  // initial priority register
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata
);

  // Controller sequences IDLE -> SCAN (one slot per cycle) -> DRAIN -> FIN.
  // Datapath holds the slot table, the scan accumulators and the result register.
  pit_cmd_t cmd;
  pit_sts_t sts;

  pit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pit_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
